### sv/hxf_pkg.sv
`default_nettype none

package hxf_pkg;

    localparam int DIM       = 4;
    localparam int FRAC_BITS = 16;
    localparam int QW        = 32;
    localparam int CSW       = 18;
    localparam int ACTW      = 3;
    localparam int AXW       = 2;
    localparam int ROWW      = $clog2(DIM);
    localparam int IDXW      = 2 * ROWW;
    localparam int PW        = 2 * QW - FRAC_BITS;
    localparam int SUMW      = PW + 2;
    localparam int QDEPTH    = 4;
    localparam int QPTRW     = $clog2(QDEPTH);

    typedef logic signed [QW-1:0] t_q;

    localparam t_q Q_ONE = QW'(1 << FRAC_BITS);
    localparam t_q Q_ZERO = '0;

    localparam logic signed [SUMW-1:0] SUM_MAX = SUMW'({1'b0, {(QW-1){1'b1}}});
    localparam logic signed [SUMW-1:0] SUM_MIN = ~SUM_MAX;

    localparam logic [ACTW-1:0] ACT_LOAD   = ACTW'(0);
    localparam logic [ACTW-1:0] ACT_IDENT  = ACTW'(1);
    localparam logic [ACTW-1:0] ACT_SCALE  = ACTW'(2);
    localparam logic [ACTW-1:0] ACT_TRANS  = ACTW'(3);
    localparam logic [ACTW-1:0] ACT_ROTATE = ACTW'(4);
    localparam logic [ACTW-1:0] ACT_POINT  = ACTW'(5);

    localparam logic [AXW-1:0] AX_X = AXW'(0);
    localparam logic [AXW-1:0] AX_Y = AXW'(1);
    localparam logic [AXW-1:0] AX_Z = AXW'(2);

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_IDENT,
        OP_SCALE,
        OP_TRANS,
        OP_ROT_X,
        OP_ROT_Y,
        OP_ROT_Z,
        OP_POINT
    } t_op;

    typedef struct packed {
        t_op                    op;
        logic [IDXW-1:0]        idx;
        logic signed [QW-1:0]   a;
        logic signed [QW-1:0]   b;
        logic signed [QW-1:0]   c;
        logic signed [QW-1:0]   d;
        logic signed [CSW-1:0]  cs;
        logic signed [CSW-1:0]  sn;
    } t_req;

endpackage

`default_nettype wire

### sv/hxf_front.sv
`default_nettype none

module hxf_front import hxf_pkg::*; (
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [ACTW-1:0]        i_action,
    input  logic [IDXW-1:0]        i_coef_index,
    input  logic signed [QW-1:0]   i_coef_value,
    input  logic signed [QW-1:0]   i_arg_a,
    input  logic signed [QW-1:0]   i_arg_b,
    input  logic signed [QW-1:0]   i_arg_c,
    input  logic signed [QW-1:0]   i_arg_d,
    input  logic [AXW-1:0]         i_axis,
    input  logic signed [CSW-1:0]  i_cosine,
    input  logic signed [CSW-1:0]  i_sine,
    input  logic                   i_q_full,
    output logic                   o_push,
    output t_req                   o_req
);

    logic keep;
    t_op  op;

    always_comb begin
        keep = 1'b1;
        op   = OP_POINT;
        unique case (i_action)
            ACT_LOAD:   op = OP_LOAD;
            ACT_IDENT:  op = OP_IDENT;
            ACT_SCALE:  op = OP_SCALE;
            ACT_TRANS:  op = OP_TRANS;
            ACT_ROTATE: begin
                unique case (i_axis)
                    AX_X:    op = OP_ROT_X;
                    AX_Y:    op = OP_ROT_Y;
                    AX_Z:    op = OP_ROT_Z;
                    default: keep = 1'b0;
                endcase
            end
            ACT_POINT:  op = OP_POINT;
            default:    keep = 1'b0;
        endcase
    end

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full && keep;

    always_comb begin
        o_req     = '0;
        o_req.op  = op;
        o_req.idx = i_coef_index;
        o_req.a   = i_arg_a;
        o_req.b   = i_arg_b;
        o_req.c   = i_arg_c;
        // load value rides in the w slot
        o_req.d   = (op == OP_LOAD) ? i_coef_value : i_arg_d;
        o_req.cs  = i_cosine;
        o_req.sn  = i_sine;
    end

endmodule

`default_nettype wire

### sv/hxf_queue.sv
`default_nettype none

module hxf_queue import hxf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_req  i_req,
    output logic  o_full,
    output logic  o_valid,
    input  logic  i_pop,
    output t_req  o_req
);

    t_req             r_mem [QDEPTH];
    logic [QPTRW-1:0] r_wr;
    logic [QPTRW-1:0] r_rd;
    logic [QPTRW:0]   r_cnt;
    logic [QPTRW-1:0] n_wr;
    logic [QPTRW-1:0] n_rd;
    logic [QPTRW:0]   n_cnt;

    assign o_full  = (r_cnt == (QPTRW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_req   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == QPTRW'(QDEPTH-1)) ? '0 : r_wr + QPTRW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == QPTRW'(QDEPTH-1)) ? '0 : r_rd + QPTRW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (QPTRW+1)'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - (QPTRW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_req;
        end
    end

endmodule

`default_nettype wire

### sv/hxf_back.sv
`default_nettype none

module hxf_back import hxf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  t_req                  i_q_req,
    output logic                  o_q_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [QW-1:0]  o_out_x,
    output logic signed [QW-1:0]  o_out_y,
    output logic signed [QW-1:0]  o_out_z,
    output logic signed [QW-1:0]  o_out_w
);

    typedef enum logic [2:0] {
        SQ_RUN   = 3'b001,
        SQ_ROWS  = 3'b010,
        SQ_DRAIN = 3'b100
    } t_seq;

    t_q r_mat [DIM][DIM];
    t_q r_nxt [DIM-1][DIM];

    t_seq            r_seq;
    t_seq            n_seq;
    logic [ROWW-1:0] r_row;
    logic [ROWW-1:0] n_row;
    t_req            r_upd;

    logic                   r_s1_vld;
    logic                   r_s1_upd;
    logic                   r_s1_last;
    logic [ROWW-1:0]        r_s1_row;
    logic signed [2*QW-1:0] r_s1_prod [DIM][DIM];

    logic                   r_s2_vld;
    logic                   r_s2_upd;
    logic                   r_s2_last;
    logic [ROWW-1:0]        r_s2_row;
    logic signed [PW:0]     r_s2_pair [DIM][2];

    logic                   r_out_valid;
    t_q                     r_out [DIM];

    logic adv;
    logic head_upd;
    logic issue_pop;
    logic point_issue;
    logic row_issue;
    logic commit;
    logic s2_write;

    t_q                     op_a [DIM][DIM];
    t_q                     op_b [DIM][DIM];
    logic signed [2*QW-1:0] prod [DIM][DIM];
    logic signed [SUMW-1:0] tot  [DIM];
    t_q                     res  [DIM];

    function automatic t_q arg_sel(input t_req req, input logic [ROWW-1:0] r);
        t_q v;
        if (r == ROWW'(0)) begin
            v = req.a;
        end else if (r == ROWW'(1)) begin
            v = req.b;
        end else begin
            v = req.c;
        end
        return v;
    endfunction

    function automatic t_q pt_sel(input t_req req, input logic [ROWW-1:0] k);
        t_q v;
        if (k == ROWW'(0)) begin
            v = req.a;
        end else if (k == ROWW'(1)) begin
            v = req.b;
        end else if (k == ROWW'(2)) begin
            v = req.c;
        end else begin
            v = req.d;
        end
        return v;
    endfunction

    // coefficient (r, k) of the left factor
    function automatic t_q t_elem(input t_req req, input logic [ROWW-1:0] r,
                                  input logic [ROWW-1:0] k);
        t_q   cs;
        t_q   sn;
        t_q   nsn;
        t_q   v;
        logic r0, r1, r2, k0, k1, k2;
        cs  = QW'(req.cs);
        sn  = QW'(req.sn);
        nsn = -sn;
        r0  = (r == ROWW'(0));
        r1  = (r == ROWW'(1));
        r2  = (r == ROWW'(2));
        k0  = (k == ROWW'(0));
        k1  = (k == ROWW'(1));
        k2  = (k == ROWW'(2));
        v   = (r == k) ? Q_ONE : Q_ZERO;
        unique case (req.op)
            OP_SCALE: begin
                if (r == k && r != ROWW'(DIM-1)) v = arg_sel(req, r);
            end
            OP_TRANS: begin
                if (k == ROWW'(DIM-1) && r != ROWW'(DIM-1)) v = arg_sel(req, r);
            end
            OP_ROT_X: begin
                if      (r1 && k1) v = cs;
                else if (r1 && k2) v = nsn;
                else if (r2 && k1) v = sn;
                else if (r2 && k2) v = cs;
            end
            OP_ROT_Y: begin
                if      (r0 && k0) v = cs;
                else if (r0 && k2) v = sn;
                else if (r2 && k0) v = nsn;
                else if (r2 && k2) v = cs;
            end
            OP_ROT_Z: begin
                if      (r0 && k0) v = cs;
                else if (r0 && k1) v = nsn;
                else if (r1 && k0) v = sn;
                else if (r1 && k1) v = cs;
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic signed [PW-1:0] shq(input logic signed [2*QW-1:0] p);
        return $signed(p[2*QW-1:FRAC_BITS]);
    endfunction

    function automatic t_q sat(input logic signed [SUMW-1:0] s);
        t_q v;
        if (s > SUM_MAX) begin
            v = QW'(SUM_MAX);
        end else if (s < SUM_MIN) begin
            v = QW'(SUM_MIN);
        end else begin
            v = QW'(s);
        end
        return v;
    endfunction

    assign adv       = !r_out_valid || i_out_ready;
    assign head_upd  = (i_q_req.op == OP_SCALE) || (i_q_req.op == OP_TRANS) ||
                       (i_q_req.op == OP_ROT_X) || (i_q_req.op == OP_ROT_Y) ||
                       (i_q_req.op == OP_ROT_Z);
    assign issue_pop   = i_q_valid && (r_seq == SQ_RUN) && adv;
    assign point_issue = issue_pop && (i_q_req.op == OP_POINT);
    assign row_issue   = (r_seq == SQ_ROWS) && adv;
    assign s2_write    = adv && r_s2_vld && r_s2_upd;
    assign commit      = s2_write && r_s2_last;
    assign o_q_pop     = issue_pop;

    // operand select: point rows of the matrix, or one row of the left product
    always_comb begin
        for (int i = 0; i < DIM; i++) begin
            for (int k = 0; k < DIM; k++) begin
                if (r_seq == SQ_ROWS) begin
                    op_a[i][k] = t_elem(r_upd, r_row, ROWW'(k));
                    op_b[i][k] = r_mat[k][i];
                end else begin
                    op_a[i][k] = r_mat[i][k];
                    op_b[i][k] = pt_sel(i_q_req, ROWW'(k));
                end
                prod[i][k] = op_a[i][k] * op_b[i][k];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < DIM; i++) begin
            tot[i] = SUMW'(r_s2_pair[i][0]) + SUMW'(r_s2_pair[i][1]);
            res[i] = sat(tot[i]);
        end
    end

    always_comb begin
        n_seq = r_seq;
        n_row = r_row;
        unique case (r_seq)
            SQ_RUN: begin
                if (issue_pop && head_upd) begin
                    n_seq = SQ_ROWS;
                    n_row = '0;
                end
            end
            SQ_ROWS: begin
                if (row_issue) begin
                    n_row = r_row + ROWW'(1);
                    if (r_row == ROWW'(DIM-1)) n_seq = SQ_DRAIN;
                end
            end
            SQ_DRAIN: begin
                if (commit) n_seq = SQ_RUN;
            end
            default: n_seq = SQ_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= SQ_RUN;
            r_row       <= '0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_seq <= n_seq;
            r_row <= n_row;
            if (adv) begin
                r_s1_vld    <= point_issue || row_issue;
                r_s2_vld    <= r_s1_vld;
                r_out_valid <= r_s2_vld && !r_s2_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue_pop && head_upd) begin
            r_upd <= i_q_req;
        end
        if (adv) begin
            r_s1_upd  <= row_issue;
            r_s1_last <= (r_row == ROWW'(DIM-1));
            r_s1_row  <= r_row;
            r_s2_upd  <= r_s1_upd;
            r_s2_last <= r_s1_last;
            r_s2_row  <= r_s1_row;
            for (int i = 0; i < DIM; i++) begin
                for (int k = 0; k < DIM; k++) begin
                    r_s1_prod[i][k] <= prod[i][k];
                end
                r_s2_pair[i][0] <= (PW+1)'(shq(r_s1_prod[i][0])) +
                                   (PW+1)'(shq(r_s1_prod[i][1]));
                r_s2_pair[i][1] <= (PW+1)'(shq(r_s1_prod[i][2])) +
                                   (PW+1)'(shq(r_s1_prod[i][3]));
            end
        end
        if (adv && r_s2_vld && !r_s2_upd) begin
            for (int i = 0; i < DIM; i++) begin
                r_out[i] <= res[i];
            end
        end
        if (s2_write && !r_s2_last) begin
            for (int c = 0; c < DIM; c++) begin
                r_nxt[r_s2_row][c] <= res[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < DIM; r++) begin
                for (int c = 0; c < DIM; c++) begin
                    r_mat[r][c] <= (r == c) ? Q_ONE : Q_ZERO;
                end
            end
        end else if (commit) begin
            for (int c = 0; c < DIM; c++) begin
                for (int r = 0; r < DIM-1; r++) begin
                    r_mat[r][c] <= r_nxt[r][c];
                end
                r_mat[DIM-1][c] <= res[c];
            end
        end else if (issue_pop && i_q_req.op == OP_LOAD) begin
            r_mat[i_q_req.idx[IDXW-1:ROWW]][i_q_req.idx[ROWW-1:0]] <= i_q_req.d;
        end else if (issue_pop && i_q_req.op == OP_IDENT) begin
            for (int r = 0; r < DIM; r++) begin
                for (int c = 0; c < DIM; c++) begin
                    r_mat[r][c] <= (r == c) ? Q_ONE : Q_ZERO;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_x     = r_out[0];
    assign o_out_y     = r_out[1];
    assign o_out_z     = r_out[2];
    assign o_out_w     = r_out[3];

`ifndef SYNTHESIS
    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_seq == SQ_RUN))
        else $error("request taken from queue during matrix update");

    a_commit_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |-> (r_seq == SQ_DRAIN))
        else $error("matrix commit outside drain");

    a_row_enters_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        row_issue |=> (r_s1_vld && r_s1_upd))
        else $error("update row lost at issue");
`endif

endmodule

`default_nettype wire

### sv/homogeneous_transform_4x4_top.sv
// channel  direction  handshake                  payload
// in       to block   i_in_valid / o_in_ready    i_action .. i_sine
// out      from block o_out_valid / i_out_ready  o_out_x .. o_out_w
//
// transform point: one request per cycle while no update runs and the output is ready
// matrix updates hold the back end for 4 row passes through the
// shared 16-multiplier array plus pipeline drain before the new matrix commits
// load and identity write the matrix as they leave the queue; the 4-entry queue keeps taking requests meanwhile
// reset is synchronous active low and sets the matrix to identity
// a stalled output freezes the whole multiply pipeline
`default_nettype none

module homogeneous_transform_4x4_top import hxf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [ACTW-1:0]        i_action,
    input  logic [IDXW-1:0]        i_coef_index,
    input  logic signed [QW-1:0]   i_coef_value,
    input  logic signed [QW-1:0]   i_arg_a,
    input  logic signed [QW-1:0]   i_arg_b,
    input  logic signed [QW-1:0]   i_arg_c,
    input  logic signed [QW-1:0]   i_arg_d,
    input  logic [AXW-1:0]         i_axis,
    input  logic signed [CSW-1:0]  i_cosine,
    input  logic signed [CSW-1:0]  i_sine,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic signed [QW-1:0]   o_out_x,
    output logic signed [QW-1:0]   o_out_y,
    output logic signed [QW-1:0]   o_out_z,
    output logic signed [QW-1:0]   o_out_w
);

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_req f_req;
    t_req q_req;

    hxf_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_arg_a      (i_arg_a),
        .i_arg_b      (i_arg_b),
        .i_arg_c      (i_arg_c),
        .i_arg_d      (i_arg_d),
        .i_axis       (i_axis),
        .i_cosine     (i_cosine),
        .i_sine       (i_sine),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_req        (f_req)
    );

    hxf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_req   (f_req),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_req   (q_req)
    );

    hxf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_req     (q_req),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_out_w     (o_out_w)
    );

endmodule

`default_nettype wire

### bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hxf_pkg::*;

    localparam logic [ACTW-1:0] ACT_SPARE6 = ACTW'(6);
    localparam logic [ACTW-1:0] ACT_SPARE7 = ACTW'(7);
    localparam logic [AXW-1:0]  AX_NONE    = AXW'(3);
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -SAT_HI - 1;
    localparam t_q Q_MAX = 32'sh7fffffff;
    localparam t_q Q_MIN = 32'sh80000000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [ACTW-1:0]       action;
        logic [IDXW-1:0]       idx;
        t_q                    val;
        t_q                    a;
        t_q                    b;
        t_q                    c;
        t_q                    d;
        logic [AXW-1:0]        axis;
        logic signed [CSW-1:0] cs;
        logic signed [CSW-1:0] sn;
    } t_xf_req;

    typedef logic [DIM-1:0][QW-1:0] t_point;

    class xform_model;
        t_q     coef[DIM*DIM];
        t_point expected_points[$];
        int     errors;

        function new();
            load_identity(coef);
            errors = 0;
        endfunction

        static function void load_identity(output t_q m[DIM*DIM]);
            for (int i = 0; i < DIM*DIM; i++) begin
                m[i] = (i % (DIM + 1) == 0) ? Q_ONE : Q_ZERO;
            end
        endfunction

        // exact product, low fraction bits dropped toward minus infinity
        static function longint qmul(t_q x, t_q y);
            return (longint'(x) * longint'(y)) >>> FRAC_BITS;
        endfunction

        static function t_q sat(longint v);
            if (v > SAT_HI) return Q_MAX;
            if (v < SAT_LO) return Q_MIN;
            return t_q'(v);
        endfunction

        function void left_mul(input t_q t[DIM*DIM]);
            t_q     nm[DIM*DIM];
            longint acc;
            for (int row = 0; row < DIM; row++) begin
                for (int col = 0; col < DIM; col++) begin
                    acc = 0;
                    for (int k = 0; k < DIM; k++) begin
                        acc += qmul(t[row*DIM+k], coef[k*DIM+col]);
                    end
                    nm[row*DIM+col] = sat(acc);
                end
            end
            coef = nm;
        endfunction

        function void note_request(t_xf_req r);
            t_q     t[DIM*DIM];
            t_q     cs;
            t_q     sn;
            t_point p;
            longint acc;
            cs = r.cs;
            sn = r.sn;
            load_identity(t);
            case (r.action)
                ACT_LOAD: coef[r.idx] = r.val;
                ACT_IDENT: coef = t;
                ACT_SCALE: begin
                    t[0] = r.a; t[5] = r.b; t[10] = r.c;
                    left_mul(t);
                end
                ACT_TRANS: begin
                    t[3] = r.a; t[7] = r.b; t[11] = r.c;
                    left_mul(t);
                end
                ACT_ROTATE: begin
                    case (r.axis)
                        AX_X: begin
                            t[5] = cs; t[6] = -sn; t[9] = sn; t[10] = cs;
                        end
                        AX_Y: begin
                            t[0] = cs; t[2] = sn; t[8] = -sn; t[10] = cs;
                        end
                        AX_Z: begin
                            t[0] = cs; t[1] = -sn; t[4] = sn; t[5] = cs;
                        end
                        default: ;
                    endcase
                    if (r.axis != AX_NONE) left_mul(t);
                end
                ACT_POINT: begin
                    for (int row = 0; row < DIM; row++) begin
                        acc = qmul(coef[row*DIM], r.a) + qmul(coef[row*DIM+1], r.b)
                            + qmul(coef[row*DIM+2], r.c) + qmul(coef[row*DIM+3], r.d);
                        p[row] = sat(acc);
                    end
                    expected_points.push_back(p);
                end
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_points.size();
        endfunction

        task report(string what);
            errors++;
            $display("mismatch: %s", what);
        endtask

        task check_point(t_point got);
            t_point want;
            string  names;
            names = "xyzw";
            if (expected_points.size() == 0) begin
                report($sformatf("point %h with no request waiting", got));
                return;
            end
            want = expected_points.pop_front();
            for (int i = 0; i < DIM; i++) begin
                if (got[i] !== want[i]) begin
                    report($sformatf("out_%c got %h expected %h", names[i], got[i], want[i]));
                end
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [ACTW-1:0]       i_action;
    logic [IDXW-1:0]       i_coef_index;
    logic signed [QW-1:0]  i_coef_value;
    logic signed [QW-1:0]  i_arg_a;
    logic signed [QW-1:0]  i_arg_b;
    logic signed [QW-1:0]  i_arg_c;
    logic signed [QW-1:0]  i_arg_d;
    logic [AXW-1:0]        i_axis;
    logic signed [CSW-1:0] i_cosine;
    logic signed [CSW-1:0] i_sine;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic signed [QW-1:0]  o_out_x;
    logic signed [QW-1:0]  o_out_y;
    logic signed [QW-1:0]  o_out_z;
    logic signed [QW-1:0]  o_out_w;

    xform_model model;
    int tx_idle_pct = 9;
    int rx_idle_pct = 79;

    homogeneous_transform_4x4_top uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    initial begin
        forever begin
            @(negedge i_clk);
            i_out_ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                model.check_point({o_out_w, o_out_z, o_out_y, o_out_x});
            end
        end
    end

    function automatic t_q rand_q();
        int sel;
        sel = $urandom_range(9);
        if (sel < 2) return t_q'($urandom);
        if (sel == 2) begin
            case ($urandom_range(4))
                0: return Q_MAX;
                1: return Q_MIN;
                2: return Q_ZERO;
                3: return Q_ONE;
                default: return -Q_ONE;
            endcase
        end
        return t_q'(int'($urandom_range(8*65536)) - 4*65536);
    endfunction

    // scale factors mostly within -2.0 .. +2.0 so the matrix does not pin at the limits
    function automatic t_q rand_gain();
        if ($urandom_range(4) == 0) return rand_q();
        return t_q'(int'($urandom_range(4*65536)) - 2*65536);
    endfunction

    function automatic logic signed [CSW-1:0] rand_trig();
        if ($urandom_range(9) == 0) return CSW'($urandom);
        return CSW'(int'($urandom_range(2*65536)) - 65536);
    endfunction

    function automatic t_xf_req noise_req();
        t_xf_req r;
        r.action = ACTW'($urandom);
        r.idx    = IDXW'($urandom);
        r.val    = t_q'($urandom);
        r.a      = t_q'($urandom);
        r.b      = t_q'($urandom);
        r.c      = t_q'($urandom);
        r.d      = t_q'($urandom);
        r.axis   = AXW'($urandom);
        r.cs     = CSW'($urandom);
        r.sn     = CSW'($urandom);
        return r;
    endfunction

    function automatic t_xf_req random_req();
        t_xf_req r;
        int      pick;
        r = noise_req();
        pick = $urandom_range(99);
        if (pick < 50) begin
            r.action = ACT_POINT;
            r.a = rand_q();
            r.b = rand_q();
            r.c = rand_q();
            r.d = ($urandom_range(9) < 7) ? Q_ONE : rand_q();
        end else if (pick < 62) begin
            r.action = ACT_LOAD;
            r.val = rand_q();
        end else if (pick < 66) begin
            r.action = ACT_IDENT;
        end else if (pick < 73) begin
            r.action = ACT_SCALE;
            r.a = rand_gain();
            r.b = rand_gain();
            r.c = rand_gain();
        end else if (pick < 80) begin
            r.action = ACT_TRANS;
            r.a = rand_q();
            r.b = rand_q();
            r.c = rand_q();
        end else if (pick < 94) begin
            r.action = ACT_ROTATE;
            r.axis = AXW'($urandom_range(3));
            r.cs = rand_trig();
            r.sn = rand_trig();
        end else begin
            r.action = ($urandom_range(1) == 0) ? ACT_SPARE6 : ACT_SPARE7;
        end
        return r;
    endfunction

    task automatic send_req(input t_xf_req r);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_action     = r.action;
        i_coef_index = r.idx;
        i_coef_value = r.val;
        i_arg_a      = r.a;
        i_arg_b      = r.b;
        i_arg_c      = r.c;
        i_arg_d      = r.d;
        i_axis       = r.axis;
        i_cosine     = r.cs;
        i_sine       = r.sn;
        i_in_valid   = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        model.note_request(r);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (model.pending() != 0) @(negedge i_clk);
    endtask

    task automatic send_point(t_q a, t_q b, t_q c, t_q d);
        t_xf_req r;
        r = noise_req();
        r.action = ACT_POINT;
        r.a = a; r.b = b; r.c = c; r.d = d;
        send_req(r);
    endtask

    task automatic send_load(logic [IDXW-1:0] idx, t_q val);
        t_xf_req r;
        r = noise_req();
        r.action = ACT_LOAD;
        r.idx = idx;
        r.val = val;
        send_req(r);
    endtask

    task automatic send_update(logic [ACTW-1:0] act, t_q a, t_q b, t_q c);
        t_xf_req r;
        r = noise_req();
        r.action = act;
        r.a = a; r.b = b; r.c = c;
        send_req(r);
    endtask

    task automatic send_rotate(logic [AXW-1:0] axis, logic signed [CSW-1:0] cs,
                               logic signed [CSW-1:0] sn);
        t_xf_req r;
        r = noise_req();
        r.action = ACT_ROTATE;
        r.axis = axis;
        r.cs = cs;
        r.sn = sn;
        send_req(r);
    endtask

    task automatic run_random(int n);
        t_xf_req r;
        int      done;
        done = 0;
        while (done < n) begin
            r = random_req();
            done++;
            send_req(r);
            if ($urandom_range(399) == 0) wait_drained();
        end
    endtask

    initial begin
        model = new();
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_action     = ACT_LOAD;
        i_coef_index = '0;
        i_coef_value = '0;
        i_arg_a      = '0;
        i_arg_b      = '0;
        i_arg_c      = '0;
        i_arg_d      = '0;
        i_axis       = AX_X;
        i_cosine     = '0;
        i_sine       = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, every action, saturation, odd axis and spare codes
        send_point(Q_MAX, Q_MIN, Q_ZERO, Q_ONE);
        send_point(-1, 1, Q_MIN, Q_MAX);
        send_load(3, Q_MAX);
        send_load(12, Q_MIN);
        send_point(Q_ONE, Q_ONE, Q_ONE, 2 * Q_ONE);
        send_load(15, Q_ZERO);
        send_load(0, 32'sh00018000);
        send_point(Q_MIN, Q_MAX, -Q_ONE, Q_MIN);
        send_update(ACT_IDENT, Q_ZERO, Q_ZERO, Q_ZERO);
        send_update(ACT_SCALE, Q_MAX, Q_MIN, -Q_ONE);
        send_point(Q_ONE, -Q_ONE, 3 * Q_ONE, Q_ONE);
        send_update(ACT_IDENT, Q_MAX, Q_MIN, Q_MAX);
        send_update(ACT_TRANS, 3 * Q_ONE, -Q_ONE, Q_MIN);
        send_point(Q_ONE, Q_ONE, -Q_ONE, Q_ONE);
        send_point(Q_MAX, Q_ZERO, Q_ZERO, Q_ONE);
        send_update(ACT_IDENT, Q_ZERO, Q_ZERO, Q_ZERO);
        send_rotate(AX_X, 32768, 56756);
        send_point(Q_ONE, 2 * Q_ONE, 3 * Q_ONE, Q_ONE);
        send_rotate(AX_Y, -65536, 65536);
        send_rotate(AX_Z, 131071, -131072);
        send_point(Q_ONE, 2 * Q_ONE, 3 * Q_ONE, Q_ONE);
        send_rotate(AX_NONE, -131072, 131071);
        send_update(ACT_SPARE6, Q_MAX, Q_MAX, Q_MAX);
        send_update(ACT_SPARE7, Q_MIN, Q_MIN, Q_MIN);
        send_point(-Q_ONE, -Q_ONE, Q_MAX, Q_ZERO);
        send_update(ACT_IDENT, Q_ZERO, Q_ZERO, Q_ZERO);

        run_random(560);
        wait_drained();
        tx_idle_pct = 79;
        rx_idle_pct = 9;
        run_random(580);
        wait_drained();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(590);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (model.errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
